/* design/gia_pkg.sv */
// Package for the generational handle allocator: sizes, request and status codes,
// the generation table word and the sequencer states. No dependencies.
`default_nettype none

package gia_pkg;

	// Slots in the table; the widths below follow from it.
	localparam int MAX_SLOTS = 1024;
	localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

	// Fixed port widths.
	localparam int KIND_W    = 2;
	localparam int IDX_W     = 10;
	localparam int GEN_W     = 32;
	localparam int STATUS_W  = 2;
	localparam int LCOUNT_W  = 11;

	// Common width for comparing port indices against counters.
	localparam int WIDE_W    = (CNT_W > LCOUNT_W) ? CNT_W : LCOUNT_W;

	localparam logic [KIND_W-1:0] K_CREATE  = 2'd0;
	localparam logic [KIND_W-1:0] K_DESTROY = 2'd1;
	localparam logic [KIND_W-1:0] K_QUERY   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DEAD = 2'd2;

	// One generation table word: live flag and current generation.
	typedef struct packed {
		logic             live;
		logic [GEN_W-1:0] gen;
	} gen_entry_t;

	localparam int ENTRY_W = $bits(gen_entry_t);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_STK  = 3'b010,
		S_GEN  = 3'b100
	} state_t;

endpackage

`default_nettype wire

/* design/generational_id_allocator.sv */
// Generational handle allocator top level: request sequencer and result register.
// Depends on gia_pkg and gia_ram (generation table and free stack).
`default_nettype none

// Hands out handles of slot index and generation. A create reuses the most
// recently freed slot, or else takes the next fresh slot at generation 1, and
// reports full when neither exists. A destroy checks the handle, bumps the
// slot's generation (skipping 0) and pushes the slot on the free stack. A
// query reports liveness. Every result carries the slots in use. Requests
// are handled one at a time: a create that reuses a freed slot goes through
// a free stack read, then a generation table read, then write back; a destroy
// or query a generation table read, then write back; any other request goes
// straight to write back. Both RAMs have a registered read. The result sits in
// an output register, so the next request is taken while it waits; a result
// that is not taken holds the request after it in its write-back cycle.
// No clearing pass after reset: table entries are only trusted below the
// fresh-slot mark, stack entries only read below the stack depth.

module generational_id_allocator
	import gia_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [IDX_W-1:0]    slot_index,
	input  wire logic [GEN_W-1:0]    slot_gen,

	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [STATUS_W-1:0] status,
	output logic      [IDX_W-1:0]    out_index,
	output logic      [GEN_W-1:0]    out_gen,
	output logic                     is_alive,
	output logic      [LCOUNT_W-1:0] live_count
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  hw_q, hw_d;
	logic [CNT_W-1:0]  fd_q, fd_d;
	logic [CNT_W-1:0]  fd_dec;

	// latched request
	logic [KIND_W-1:0] kind_q;
	logic [WIDE_W-1:0] idx_q;
	logic [GEN_W-1:0]  gen_q;
	logic              from_stk_q;
	logic [SLOT_W-1:0] slot_q;

	// RAM ports
	logic              gen_we, gen_re;
	logic [SLOT_W-1:0] gen_waddr, gen_raddr;
	gen_entry_t        gen_wdata, gen_rdata;
	logic              stk_we, stk_re;
	logic [SLOT_W-1:0] stk_waddr, stk_raddr;
	logic [SLOT_W-1:0] stk_wdata, stk_rdata;

	// result register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]    out_index_q;
	logic [GEN_W-1:0]    out_gen_q;
	logic                is_alive_q;
	logic [LCOUNT_W-1:0] live_count_q;

	logic                in_fire, out_free, commit;
	logic [STATUS_W-1:0] res_status;
	logic [WIDE_W-1:0]   res_idx_w;
	logic [GEN_W-1:0]    res_gen;
	logic                res_alive;
	logic                alive;
	logic [GEN_W-1:0]    bumped;
	logic [WIDE_W-1:0]   lc_w;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign commit   = (state_q == S_GEN) && out_free;
	assign fd_dec   = fd_q - CNT_W'(1);

	gia_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_SLOTS)
	) u_gen_ram (
		.clk   (clk),
		.we    (gen_we),
		.waddr (gen_waddr),
		.wdata (gen_wdata),
		.re    (gen_re),
		.raddr (gen_raddr),
		.rdata (gen_rdata)
	);

	gia_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (MAX_SLOTS)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Reads: stack top then its entry on reuse, handle's entry on destroy/query.
	always_comb begin
		gen_re    = 1'b0;
		gen_raddr = '0;
		stk_re    = 1'b0;
		stk_raddr = fd_dec[SLOT_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (kind == K_CREATE && fd_q != '0) begin
						stk_re = 1'b1;
					end else if (kind == K_DESTROY || kind == K_QUERY) begin
						gen_re    = 1'b1;
						gen_raddr = SLOT_W'(slot_index);
					end
				end
			end
			S_STK: begin
				gen_re    = 1'b1;
				gen_raddr = stk_rdata;
			end
			default: begin
			end
		endcase
	end

	assign bumped = (gen_rdata.gen == '1) ? GEN_W'(1) : gen_rdata.gen + GEN_W'(1);
	assign alive  = (gen_q != '0) && (idx_q < WIDE_W'(hw_q))
		&& gen_rdata.live && (gen_rdata.gen == gen_q);

	// Write-back side: decide the result and the state update.
	always_comb begin
		hw_d       = hw_q;
		fd_d       = fd_q;
		gen_we     = 1'b0;
		gen_waddr  = idx_q[SLOT_W-1:0];
		gen_wdata  = '{live: 1'b0, gen: bumped};
		stk_we     = 1'b0;
		stk_waddr  = fd_q[SLOT_W-1:0];
		stk_wdata  = idx_q[SLOT_W-1:0];
		res_status = ST_DONE;
		res_idx_w  = '0;
		res_gen    = '0;
		res_alive  = 1'b0;
		case (kind_q)
			K_CREATE: begin
				if (from_stk_q) begin
					gen_we    = commit;
					gen_waddr = slot_q;
					gen_wdata = '{live: 1'b1, gen: gen_rdata.gen};
					fd_d      = fd_dec;
					res_idx_w = WIDE_W'(slot_q);
					res_gen   = gen_rdata.gen;
				end else if (hw_q < CNT_W'(MAX_SLOTS)) begin
					gen_we    = commit;
					gen_waddr = hw_q[SLOT_W-1:0];
					gen_wdata = '{live: 1'b1, gen: GEN_W'(1)};
					hw_d      = hw_q + CNT_W'(1);
					res_idx_w = WIDE_W'(hw_q);
					res_gen   = GEN_W'(1);
				end else begin
					res_status = ST_FULL;
				end
			end
			K_DESTROY, K_QUERY: begin
				res_alive  = alive;
				res_status = alive ? ST_DONE : ST_DEAD;
				if (alive && kind_q == K_DESTROY) begin
					gen_we = commit;
					if (fd_q < CNT_W'(MAX_SLOTS)) begin
						stk_we = commit;
						fd_d   = fd_q + CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign lc_w = WIDE_W'(hw_d) - WIDE_W'(fd_d);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_d = (kind == K_CREATE && fd_q != '0) ? S_STK : S_GEN;
				end
			end
			S_STK:   state_d = S_GEN;
			S_GEN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hw_q        <= '0;
			fd_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				hw_q        <= hw_d;
				fd_q        <= fd_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload: no reset needed.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q     <= kind;
			idx_q      <= WIDE_W'(slot_index);
			gen_q      <= slot_gen;
			from_stk_q <= (kind == K_CREATE) && (fd_q != '0);
		end
		if (state_q == S_STK) begin
			slot_q <= stk_rdata;
		end
		if (commit) begin
			status_q     <= res_status;
			out_index_q  <= res_idx_w[IDX_W-1:0];
			out_gen_q    <= res_gen;
			is_alive_q   <= res_alive;
			live_count_q <= lc_w[LCOUNT_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_index  = out_index_q;
	assign out_gen    = out_gen_q;
	assign is_alive   = is_alive_q;
	assign live_count = live_count_q;

endmodule

`default_nettype wire

/* design/gia_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; read data holds while no read is issued.
`default_nettype none

module gia_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* dv/generational_id_allocator_tb.sv */
// Self-checking bench for generational_id_allocator: a handle-table scoreboard
// predicts every reply from directed and random create/destroy/query beats.
// Depends on gia_pkg and the allocator RTL only.

module generational_id_allocator_tb;
	import gia_pkg::*;

	localparam logic [KIND_W-1:0] K_UNUSED = 2'd3;
	localparam int RANDOM_BEATS = 2000;
	localparam int QUIET_LIMIT  = 1000;
	localparam int SETTLE       = 20;
	localparam int SHOWN_FAULTS = 10;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    out_index;
		logic [GEN_W-1:0]    out_gen;
		logic                is_alive;
		logic [LCOUNT_W-1:0] live_count;
	} reply_t;

	// Mirror of the handle table plus the replies still owed by the block.
	class handle_scoreboard;
		logic [GEN_W-1:0] gen_of [MAX_SLOTS];
		bit               live_of [MAX_SLOTS];
		logic [IDX_W-1:0] free_slots [MAX_SLOTS];
		int unsigned      high_water, free_depth;
		reply_t           replies_due [$];
		int               faults, n_checked, n_fresh, n_reuse, n_full, n_freed, n_dead;
		int               n_unused, peak_live;

		function bit handle_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] g);
			if (g == '0 || idx >= high_water)
				return 1'b0;
			return live_of[idx] && gen_of[idx] == g;
		endfunction

		function void note_request(logic [KIND_W-1:0] k, logic [IDX_W-1:0] idx,
				logic [GEN_W-1:0] g);
			reply_t      res;
			int unsigned slot;
			bit          hit;
			res = '0;
			res.status = ST_DONE;
			case (k)
				K_CREATE: begin
					// reuse the most recent free first, then a fresh slot
					if (free_depth > 0) begin
						free_depth--;
						slot = free_slots[free_depth];
						n_reuse++;
					end else if (high_water < MAX_SLOTS) begin
						slot = high_water;
						gen_of[slot] = 1;
						high_water++;
						n_fresh++;
					end else begin
						slot = MAX_SLOTS;
						res.status = ST_FULL;
						n_full++;
					end
					if (slot < MAX_SLOTS) begin
						live_of[slot] = 1'b1;
						res.out_index = IDX_W'(slot);
						res.out_gen = gen_of[slot];
					end
				end
				K_DESTROY, K_QUERY: begin
					hit = handle_live(idx, g);
					res.is_alive = hit;
					res.status = hit ? ST_DONE : ST_DEAD;
					if (!hit)
						n_dead++;
					if (hit && k == K_DESTROY) begin
						// skip the null generation on wrap
						gen_of[idx] = (gen_of[idx] == '1) ? GEN_W'(1) : gen_of[idx] + 1'b1;
						live_of[idx] = 1'b0;
						if (free_depth < MAX_SLOTS) begin
							free_slots[free_depth] = idx;
							free_depth++;
						end
						n_freed++;
					end
				end
				default: n_unused++;
			endcase
			res.live_count = LCOUNT_W'(high_water - free_depth);
			if (int'(high_water - free_depth) > peak_live)
				peak_live = high_water - free_depth;
			replies_due.insert(replies_due.size(), res);
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			n_checked++;
			if (replies_due.size() == 0) begin
				faults++;
				if (faults <= SHOWN_FAULTS)
					$display("reply with no request outstanding: status %0d index %0d gen %0h",
						got.status, got.out_index, got.out_gen);
				return;
			end
			want = replies_due.pop_front();
			if (got !== want) begin
				faults++;
				if (faults <= SHOWN_FAULTS) begin
					$write("reply %0d mismatch: status %0d/%0d index %0d/%0d gen %0h/%0h ",
						n_checked, want.status, got.status, want.out_index,
						got.out_index, want.out_gen, got.out_gen);
					$display("alive %0d/%0d live %0d/%0d (expected/actual)",
						want.is_alive, got.is_alive, want.live_count, got.live_count);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [KIND_W-1:0]   kind;
	logic [IDX_W-1:0]    slot_index;
	logic [GEN_W-1:0]    slot_gen;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    out_index;
	logic [GEN_W-1:0]    out_gen;
	logic                is_alive;
	logic [LCOUNT_W-1:0] live_count;

	handle_scoreboard book;
	int               send_idle_pct, recv_stall_pct;
	int               n_sent;
	int               quiet_cycles = 0;

	generational_id_allocator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.slot_index (slot_index),
		.slot_gen   (slot_gen),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_index  (out_index),
		.out_gen    (out_gen),
		.is_alive   (is_alive),
		.live_count (live_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Called just after a rising edge; returns at the edge that takes the beat.
	task automatic send_request(logic [KIND_W-1:0] k, logic [IDX_W-1:0] idx,
			logic [GEN_W-1:0] g);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		slot_index <= idx;
		slot_gen   <= g;
		do @(posedge clk); while (!in_ready);
		book.note_request(k, idx, g);
		n_sent++;
	endtask

	// Mostly creates until the table fills, then a mix around full, then drain.
	function automatic void pick_request(int phase, output logic [KIND_W-1:0] k,
			output logic [IDX_W-1:0] idx, output logic [GEN_W-1:0] g);
		int create_pct;
		int roll;
		int tries;
		create_pct = (book.high_water < MAX_SLOTS) ? 90 : ((phase == 3) ? 15 : 40);
		roll = $urandom_range(99);
		idx = IDX_W'($urandom_range((1 << IDX_W) - 1));
		g = $urandom;
		if (roll < create_pct)
			k = K_CREATE;
		else if (roll < create_pct + 2)
			k = K_UNUSED;
		else begin
			k = ($urandom_range(99) < 60) ? K_DESTROY : K_QUERY;
			if (book.high_water > 0 && $urandom_range(99) < 75) begin
				// aim at a handle that is out, else any slot taken so far
				tries = 0;
				do begin
					idx = IDX_W'($urandom_range(book.high_water - 1));
					tries++;
				end while (!book.live_of[idx] && tries < 8);
				g = book.gen_of[idx];
				if ($urandom_range(99) < 15)
					g = g - 1'b1;
			end else begin
				case ($urandom_range(3))
					0: g = '0;
					1: g = '1;
					2: g = $urandom_range(3);
					default: ;
				endcase
			end
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_reply({status, out_index, out_gen, is_alive, live_count});
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [KIND_W-1:0] k;
		logic [IDX_W-1:0]  idx;
		logic [GEN_W-1:0]  g;
		int                phase;
		book = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		n_sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = K_CREATE;
		slot_index = '0;
		slot_gen = '0;
		out_ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, null and stale handles, double free, LIFO reuse
		send_request(K_QUERY, 0, 1);
		send_request(K_DESTROY, 0, 1);
		send_request(K_CREATE, 0, 0);
		send_request(K_CREATE, '1, '1);
		send_request(K_QUERY, 0, 1);
		send_request(K_QUERY, 0, '0);
		send_request(K_QUERY, 0, '1);
		send_request(K_DESTROY, 1, 1);
		send_request(K_DESTROY, 1, 1);
		send_request(K_QUERY, 1, 2);
		send_request(K_QUERY, 1, 1);
		send_request(K_CREATE, 0, 0);
		send_request(K_QUERY, 1, 2);
		send_request(K_QUERY, '1, 1);
		send_request(K_DESTROY, '1, '0);
		send_request(K_UNUSED, '1, '1);
		send_request(K_UNUSED, 0, 0);
		send_request(K_DESTROY, 1, 2);
		send_request(K_DESTROY, 0, 1);
		send_request(K_CREATE, 0, 0);
		send_request(K_CREATE, 0, 0);
		send_request(K_CREATE, 0, 0);
		send_request(K_QUERY, 2, 1);

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			phase = n / (RANDOM_BEATS / 4);
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			pick_request(phase, k, idx, g);
			send_request(k, idx, g);
		end
		in_valid <= 1'b0;

		while (book.replies_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("%0d requests, %0d replies: %0d fresh and %0d reused creates, %0d full",
			n_sent, book.n_checked, book.n_fresh, book.n_reuse, book.n_full);
		$display("%0d frees, %0d dead-handle replies, %0d unused kind, peak live %0d",
			book.n_freed, book.n_dead, book.n_unused, book.peak_live);
		if (book.faults == 0 && book.replies_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
